FILE: src/hbd2x_pkg.sv
// ---------------------------------------------------------------------------
// hbd2x_pkg
// Constants, tap table and shared types for the half-band decimator by two.
// ---------------------------------------------------------------------------
package hbd2x_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 18;
    localparam int ODD_TAPS      = 24;
    // outer taps reach from the current sample back to the oldest stored one
    localparam int HISTORY_DEPTH = 2 * ODD_TAPS - 2;
    localparam int HALF_DEPTH    = HISTORY_DEPTH / 2;
    localparam int CENTRE_K      = HALF_DEPTH - 1;

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int STEP_W = $clog2(ODD_TAPS + 1);
    localparam int TAP_W  = $clog2(ODD_TAPS);
    // multiplier coefficient carries one extra bit so the centre weight fits
    localparam int MCOEF_W = COEF_BITS + 1;
    localparam int PROD_W  = SAMPLE_BITS + MCOEF_W;
    localparam int ACC_W   = PROD_W + 6;
    localparam int SHR_W   = ACC_W - COEF_BITS;

    localparam logic signed [COEF_BITS-1:0] TAP_ROM [ODD_TAPS] = '{
        -18'sd3,     18'sd31,    -18'sd117,   18'sd319,   -18'sd728,   18'sd1467,
        -18'sd2711,  18'sd4722,  -18'sd7976,  18'sd13626, -18'sd25870, 18'sd82775,
         18'sd82775, -18'sd25870, 18'sd13626, -18'sd7976,  18'sd4722,  -18'sd2711,
         18'sd1467,  -18'sd728,   18'sd319,   -18'sd117,   18'sd31,    -18'sd3
    };

    typedef struct packed {
        logic clr;  // start a new sum
        logic vld;  // operand pair present this cycle
    } t_mac_op;

endpackage

FILE: src/hbd2x_mac.sv
// ---------------------------------------------------------------------------
// hbd2x_mac
// Registered multiply, wide accumulate, round half up and saturate.
// ---------------------------------------------------------------------------
module hbd2x_mac (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  hbd2x_pkg::t_mac_op                            i_op,
    input  logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]      i_sample,
    input  logic signed [hbd2x_pkg::MCOEF_W-1:0]          i_coef,
    output logic                                          o_busy,
    output logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]      o_sample,
    output logic                                          o_clip
);

    logic                                    r_prod_vld;
    logic signed [hbd2x_pkg::PROD_W-1:0]     r_prod;
    logic signed [hbd2x_pkg::ACC_W-1:0]      r_acc;
    logic signed [hbd2x_pkg::ACC_W-1:0]      rounded;
    logic signed [hbd2x_pkg::SHR_W-1:0]      scaled;
    logic [hbd2x_pkg::SHR_W-hbd2x_pkg::SAMPLE_BITS:0] upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_op.vld;
        end
        r_prod <= i_sample * i_coef;
        if (i_op.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + hbd2x_pkg::ACC_W'(r_prod);
        end
    end

    assign o_busy = r_prod_vld;

    always_comb begin
        rounded = r_acc + (hbd2x_pkg::ACC_W'(1) <<< (hbd2x_pkg::COEF_BITS - 1));
        scaled  = rounded[hbd2x_pkg::ACC_W-1:hbd2x_pkg::COEF_BITS];
        upper   = scaled[hbd2x_pkg::SHR_W-1:hbd2x_pkg::SAMPLE_BITS-1];
        // out of range unless all bits above the sample's sign agree with it
        o_clip  = !((&upper) || !(|upper));
        if (!o_clip) begin
            o_sample = scaled[hbd2x_pkg::SAMPLE_BITS-1:0];
        end else if (scaled[hbd2x_pkg::SHR_W-1]) begin
            o_sample = {1'b1, {(hbd2x_pkg::SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(hbd2x_pkg::SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

FILE: src/halfband_decimator_2x.sv
// ---------------------------------------------------------------------------
// halfband_decimator_2x
// Polyphase half-band FIR decimator by two over a circular sample memory.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_sample_in
//  output    out        o_out_valid / i_out_ready  o_sample_out, o_clipped
//
//  an input transaction that yields no result writes its sample straight into memory
//  a result transaction: the accept, the reads of the sample memory (one read port)
//  feeding one multiplier, with the last tap taken from the current sample, the
//  drain through the s1 and product registers, then one write back
//  the output register holds a finished result while new input is accepted;
//  a full output register holds the block at the end of its next result
//  reset is synchronous; a fill count masks memory entries not yet written
// ---------------------------------------------------------------------------
module halfband_decimator_2x (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]  i_sample_in,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]  o_sample_out,
    output logic                                      o_clipped
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                                     r_state;
    logic [hbd2x_pkg::PTR_W-1:0]                r_wp;
    logic [hbd2x_pkg::CNT_W-1:0]                r_fill;
    logic                                       r_phase;
    logic [hbd2x_pkg::STEP_W-1:0]               r_step;
    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   r_cur;

    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   r_mem [hbd2x_pkg::HISTORY_DEPTH];
    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   r_rd_data;

    logic                                       r_s1_vld;
    logic                                       r_s1_zero;
    logic                                       r_s1_cur;
    logic signed [hbd2x_pkg::MCOEF_W-1:0]       r_s1_coef;

    logic                                       r_out_vld;
    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   r_out_sample;
    logic                                       r_out_clip;

    logic                                       in_acc;
    logic                                       want_result;
    logic                                       finish;
    logic                                       advance;
    logic                                       mem_we;
    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   mem_wdata;
    logic [hbd2x_pkg::PTR_W:0]                  rd_off;
    logic [hbd2x_pkg::PTR_W:0]                  rd_sum;
    logic [hbd2x_pkg::PTR_W-1:0]                rd_addr;
    logic [hbd2x_pkg::PTR_W:0]                  rd_k;
    logic [hbd2x_pkg::TAP_W-1:0]                tap_idx;
    logic                                       n_zero;
    logic                                       n_cur;
    logic signed [hbd2x_pkg::MCOEF_W-1:0]       n_coef;
    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   mac_sample;
    hbd2x_pkg::t_mac_op                         mac_op;
    logic                                       mac_busy;
    logic signed [hbd2x_pkg::SAMPLE_BITS-1:0]   mac_result;
    logic                                       mac_clip;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign want_result  = r_phase &&
                          (r_fill >= hbd2x_pkg::CNT_W'(hbd2x_pkg::HALF_DEPTH));
    assign finish       = (r_state == S_DRAIN) && !r_s1_vld && !mac_busy &&
                          (!r_out_vld || i_out_ready);
    // the sample goes into memory once every tap read of it is done
    assign advance      = (in_acc && !want_result) || finish;
    assign mem_we       = advance;
    assign mem_wdata    = finish ? r_cur : i_sample_in;

    // read address and mask for the current step; step 0 is the centre tap
    always_comb begin
        if (r_step == '0) begin
            rd_off  = (hbd2x_pkg::PTR_W+1)'(hbd2x_pkg::HALF_DEPTH);
            rd_k    = (hbd2x_pkg::PTR_W+1)'(hbd2x_pkg::CENTRE_K);
            tap_idx = '0;
            n_coef  = hbd2x_pkg::MCOEF_W'(1) <<< (hbd2x_pkg::COEF_BITS - 1);
        end else begin
            rd_off  = (hbd2x_pkg::PTR_W+1)'({r_step, 1'b0}) - (hbd2x_pkg::PTR_W+1)'(2);
            rd_k    = (hbd2x_pkg::PTR_W+1)'(hbd2x_pkg::HISTORY_DEPTH + 1) -
                      (hbd2x_pkg::PTR_W+1)'({r_step, 1'b0});
            tap_idx = hbd2x_pkg::TAP_W'(r_step - hbd2x_pkg::STEP_W'(1));
            n_coef  = hbd2x_pkg::MCOEF_W'(hbd2x_pkg::TAP_ROM[tap_idx]);
        end
        rd_sum = {1'b0, r_wp} + rd_off;
        if (rd_sum >= (hbd2x_pkg::PTR_W+1)'(hbd2x_pkg::HISTORY_DEPTH)) begin
            rd_addr = hbd2x_pkg::PTR_W'(rd_sum -
                      (hbd2x_pkg::PTR_W+1)'(hbd2x_pkg::HISTORY_DEPTH));
        end else begin
            rd_addr = hbd2x_pkg::PTR_W'(rd_sum);
        end
        // last tap multiplies the sample of this transaction
        n_cur  = (r_step == hbd2x_pkg::STEP_W'(hbd2x_pkg::ODD_TAPS));
        n_zero = !n_cur && ((hbd2x_pkg::CNT_W+1)'(rd_k) >=
                            (hbd2x_pkg::CNT_W+1)'(r_fill));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_fill    <= '0;
            r_phase   <= 1'b0;
            r_step    <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == S_RUN);
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (in_acc && want_result) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + hbd2x_pkg::STEP_W'(1);
                    if (n_cur) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (advance) begin
                r_phase <= !r_phase;
                if (r_wp == hbd2x_pkg::PTR_W'(hbd2x_pkg::HISTORY_DEPTH - 1)) begin
                    r_wp <= '0;
                end else begin
                    r_wp <= r_wp + hbd2x_pkg::PTR_W'(1);
                end
                if (r_fill != hbd2x_pkg::CNT_W'(hbd2x_pkg::HISTORY_DEPTH)) begin
                    r_fill <= r_fill + hbd2x_pkg::CNT_W'(1);
                end
            end
        end
        if (in_acc) begin
            r_cur <= i_sample_in;
        end
        r_s1_zero <= n_zero;
        r_s1_cur  <= n_cur;
        r_s1_coef <= n_coef;
        if (finish) begin
            r_out_sample <= mac_result;
            r_out_clip   <= mac_clip;
        end
    end

    assign mac_op.clr = in_acc && want_result;
    assign mac_op.vld = r_s1_vld;
    assign mac_sample = r_s1_zero ? '0 : (r_s1_cur ? r_cur : r_rd_data);

    hbd2x_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (mac_op),
        .i_sample (mac_sample),
        .i_coef   (r_s1_coef),
        .o_busy   (mac_busy),
        .o_sample (mac_result),
        .o_clip   (mac_clip)
    );

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

    // a result is only produced on an odd index after warm-up
    a_result_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> want_result)
        else $error("result finished outside an output slot");

    // fill count and write pointer stay inside the memory
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= hbd2x_pkg::CNT_W'(hbd2x_pkg::HISTORY_DEPTH)) &&
        (r_wp < hbd2x_pkg::PTR_W'(hbd2x_pkg::HISTORY_DEPTH)))
        else $error("fill count or write pointer out of range");

    // pipeline is empty whenever a new transaction can start
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !mac_busy))
        else $error("mac pipeline busy while idle");

    // pointer only moves with a memory write
    a_wp_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mem_we |=> $stable(r_wp))
        else $error("write pointer moved without a write");

endmodule
